### hdl/ffpow_pkg.sv
// Shared single-precision arithmetic for the fast pow pipeline: add, multiply,
// round/pack, small int-to-float, round-to-integer and the polynomial constants.
`timescale 1ns / 1ps
package ffpow_pkg;

    localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] FP_NEG_HALF = 32'hBF00_0000;
    localparam logic [31:0] FP_CLAMP_HI = 32'h4301_0000;
    localparam logic [31:0] FP_CLAMP_LO = 32'hC2FD_FFFF;

    localparam logic [31:0] LG_C4 = 32'h3D74_552F;
    localparam logic [31:0] LG_C3 = 32'hBEEE_7397;
    localparam logic [31:0] LG_C2 = 32'h3FBD_96DD;
    localparam logic [31:0] LG_C1 = 32'hC021_53F6;
    localparam logic [31:0] LG_C0 = 32'h4038_D96C;

    localparam logic [31:0] EX_C3 = 32'h3D9F_CB52;
    localparam logic [31:0] EX_C2 = 32'h3E67_7E26;
    localparam logic [31:0] EX_C1 = 32'h3F32_2226;
    localparam logic [31:0] EX_C0 = 32'h3F7F_FB19;

    function automatic logic [5:0] fp_clz48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] fp_clz50(input logic [49:0] v);
        logic [5:0] n;
        n = 6'd50;
        for (int i = 0; i < 50; i++)
        begin
            if (v[i])
            begin
                n = 6'(49 - i);
            end
        end
        return n;
    endfunction

    // w has its leading one at bit 47; e is the biased exponent of that bit
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                            input logic [47:0] w, input logic st);
        logic [11:0] sh;
        logic [5:0]  shc;
        logic [47:0] ws;
        logic        sts;
        logic [11:0] ebu;
        logic [23:0] m24;
        logic        g;
        logic        inc;
        logic [33:0] word;
        if (e < 12'sd1)
        begin
            sh  = 12'(12'sd1 - e);
            shc = (sh > 12'd48) ? 6'd48 : sh[5:0];
            ws  = w >> shc;
            sts = st | (|(w & ((48'd1 << shc) - 48'd1)));
            ebu = 12'd0;
        end
        else
        begin
            ws  = w;
            sts = st;
            ebu = 12'(e - 12'sd1);
        end
        m24  = ws[47:24];
        g    = ws[23];
        inc  = g & (sts | (|ws[22:0]) | m24[0]);
        word = (34'(ebu) << 23) + 34'(m24) + 34'(inc);
        if (word >= 34'h0_7F80_0000)
        begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, word[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        logic [47:0] p;
        logic [5:0]  lz;
        logic signed [11:0] e;
        s      = a[31] ^ b[31];
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
        begin
            return FP_QNAN;
        end
        if (inf_a || inf_b)
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (zero_a || zero_b)
        begin
            return {s, 31'd0};
        end
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = 48'(ma) * 48'(mb);
        lz = fp_clz48(p);
        e  = $signed(12'(ea) + 12'(eb) - 12'd126 - 12'(lz));
        return fp_pack(s, e, p << lz, 1'b0);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a, nan_b, inf_a, inf_b;
        logic [31:0] x, y;
        logic [23:0] mx, my;
        logic [7:0]  ex, ey, d;
        logic [5:0]  dc;
        logic [49:0] xw, yw0, yw, r, rn;
        logic        stk;
        logic [5:0]  lz;
        logic signed [11:0] e;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
        begin
            return FP_QNAN;
        end
        if (inf_a)
        begin
            return a;
        end
        if (inf_b)
        begin
            return b;
        end
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
        begin
            return {a[31] & b[31], 31'd0};
        end
        if (a[30:0] < b[30:0])
        begin
            x = b;
            y = a;
        end
        else
        begin
            x = a;
            y = b;
        end
        mx  = {x[30:23] != 8'd0, x[22:0]};
        my  = {y[30:23] != 8'd0, y[22:0]};
        ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d   = ex - ey;
        dc  = (d > 8'd50) ? 6'd50 : d[5:0];
        xw  = {1'b0, mx, 25'd0};
        yw0 = {1'b0, my, 25'd0};
        yw  = yw0 >> dc;
        stk = |(yw0 & ((50'd1 << dc) - 50'd1));
        yw[0] = yw[0] | stk;
        r   = (x[31] == y[31]) ? (xw + yw) : (xw - yw);
        if (r == 50'd0)
        begin
            return 32'd0;
        end
        lz = fp_clz50(r);
        rn = r << lz;
        e  = $signed(12'(ex) + 12'd1 - 12'(lz));
        return fp_pack(x[31], e, rn[49:2], |rn[1:0]);
    endfunction

    function automatic logic [31:0] fp_i2f(input logic signed [9:0] v);
        logic       s;
        logic [9:0] mag;
        logic [3:0] p;
        logic [32:0] sh;
        s   = v[9];
        mag = s ? 10'(-v) : 10'(v);
        p   = 4'd0;
        if (mag == 10'd0)
        begin
            return 32'd0;
        end
        for (int i = 0; i < 10; i++)
        begin
            if (mag[i])
            begin
                p = 4'(i);
            end
        end
        sh = 33'(mag) << (5'd23 - 5'(p));
        return {s, 8'(8'd127 + 8'(p)), sh[22:0]};
    endfunction

    // nearest integer, ties to even; finite t with magnitude below 512
    function automatic logic signed [9:0] fp_round_int(input logic [31:0] t);
        logic [23:0] mant;
        logic [7:0]  ee;
        logic [7:0]  sh;
        logic [5:0]  shc;
        logic [33:0] fx;
        logic        stk;
        logic [9:0]  ip;
        logic [9:0]  r;
        mant = {t[30:23] != 8'd0, t[22:0]};
        ee   = (t[30:23] == 8'd0) ? 8'd1 : t[30:23];
        if (ee >= 8'd126)
        begin
            sh  = ee - 8'd126;
            fx  = 34'(mant) << sh[3:0];
            stk = 1'b0;
        end
        else
        begin
            sh  = 8'd126 - ee;
            shc = (sh > 8'd34) ? 6'd34 : sh[5:0];
            fx  = 34'(mant) >> shc;
            stk = |(34'(mant) & ((34'd1 << shc) - 34'd1));
        end
        ip = fx[33:24];
        r  = ip + 10'(fx[23] & (stk | (|fx[22:0]) | ip[0]));
        return t[31] ? $signed(10'(-r)) : $signed(r);
    endfunction

    function automatic logic [31:0] fp_key(input logic [31:0] v);
        return v[31] ? ~v : {1'b1, v[30:0]};
    endfunction

endpackage

### hdl/ffpow_log2.sv
// log2 approximation pipeline: ten stages; the polynomial takes one float operation per stage.
// Depends on ffpow_pkg; the power operand rides along to the product stage.
`timescale 1ns / 1ps
module ffpow_log2
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [31:0] base_bits,
    input  logic [31:0] power_bits,
    output logic        out_vld,
    output logic [31:0] lg_bits,
    output logic [31:0] pw_bits
);
    import ffpow_pkg::*;

    localparam int NS = 10;

    logic [NS-1:0] vld_reg;
    logic [31:0]   acc_reg  [NS];
    logic [31:0]   acc_next [NS];
    logic [31:0]   m_reg    [6];
    logic [31:0]   mm1_reg  [8];
    logic [31:0]   e_reg    [9];
    logic [31:0]   pw_reg   [NS];
    logic [31:0]   m_in;
    logic [31:0]   e_in;

    assign m_in = {9'h07F, base_bits[22:0]};
    assign e_in = fp_i2f($signed(10'(base_bits[30:23]) - 10'd127));

    assign acc_next[0] = fp_mul(LG_C4, m_in);
    assign acc_next[1] = fp_add(acc_reg[0], LG_C3);
    assign acc_next[2] = fp_mul(acc_reg[1], m_reg[1]);
    assign acc_next[3] = fp_add(acc_reg[2], LG_C2);
    assign acc_next[4] = fp_mul(acc_reg[3], m_reg[3]);
    assign acc_next[5] = fp_add(acc_reg[4], LG_C1);
    assign acc_next[6] = fp_mul(acc_reg[5], m_reg[5]);
    assign acc_next[7] = fp_add(acc_reg[6], LG_C0);
    assign acc_next[8] = fp_mul(acc_reg[7], mm1_reg[7]);
    assign acc_next[9] = fp_add(acc_reg[8], e_reg[8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
            m_reg[0]   <= m_in;
            mm1_reg[0] <= fp_add(m_in, FP_NEG_ONE);
            e_reg[0]   <= e_in;
            pw_reg[0]  <= power_bits;
            for (int k = 1; k < 6; k++)
            begin
                m_reg[k] <= m_reg[k-1];
            end
            for (int k = 1; k < 8; k++)
            begin
                mm1_reg[k] <= mm1_reg[k-1];
            end
            for (int k = 1; k < 9; k++)
            begin
                e_reg[k] <= e_reg[k-1];
            end
            for (int k = 1; k < NS; k++)
            begin
                pw_reg[k] <= pw_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[NS-1];
    assign lg_bits = acc_reg[NS-1];
    assign pw_bits = pw_reg[NS-1];

endmodule

### hdl/ffpow_exp2.sv
// exp2 approximation pipeline: clamp, round, fraction, cubic and scale,
// eleven stages; the cubic and the scale take one float operation per stage. Depends on ffpow_pkg.
`timescale 1ns / 1ps
module ffpow_exp2
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [31:0] x_bits,
    output logic        out_vld,
    output logic [31:0] result_bits
);
    import ffpow_pkg::*;

    localparam int NS = 11;

    logic [NS-1:0]      vld_reg;
    logic [31:0]        x_next;
    logic [31:0]        x0_reg, x1_reg, x2_reg;
    logic [31:0]        t1_reg;
    logic signed [9:0]  ip2_reg;
    logic [31:0]        f_reg  [3:7];
    logic [31:0]        sc_reg [3:9];
    logic [31:0]        q_reg  [4:10];
    logic [31:0]        clip_hi;
    logic               is_nan;
    logic [9:0]         biased;
    logic [31:0]        ip_flt;

    assign is_nan  = (x_bits[30:23] == 8'hFF) && (x_bits[22:0] != 23'd0);
    assign clip_hi = (!is_nan && (fp_key(x_bits) < fp_key(FP_CLAMP_HI))) ? x_bits : FP_CLAMP_HI;
    assign x_next  = (fp_key(clip_hi) > fp_key(FP_CLAMP_LO)) ? clip_hi : FP_CLAMP_LO;
    assign biased  = 10'(ip2_reg) + 10'd127;
    assign ip_flt  = fp_i2f(ip2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= x_next;
            x1_reg    <= x0_reg;
            t1_reg    <= fp_add(x0_reg, FP_NEG_HALF);
            x2_reg    <= x1_reg;
            ip2_reg   <= fp_round_int(t1_reg);
            f_reg[3]  <= fp_add(x2_reg, {~ip_flt[31], ip_flt[30:0]});
            sc_reg[3] <= {biased[8:0], 23'd0};
            q_reg[4]  <= fp_mul(EX_C3, f_reg[3]);
            q_reg[5]  <= fp_add(q_reg[4], EX_C2);
            q_reg[6]  <= fp_mul(q_reg[5], f_reg[5]);
            q_reg[7]  <= fp_add(q_reg[6], EX_C1);
            q_reg[8]  <= fp_mul(q_reg[7], f_reg[7]);
            q_reg[9]  <= fp_add(q_reg[8], EX_C0);
            q_reg[10] <= fp_mul(sc_reg[9], q_reg[9]);
            for (int k = 4; k <= 7; k++)
            begin
                f_reg[k] <= f_reg[k-1];
            end
            for (int k = 4; k <= 9; k++)
            begin
                sc_reg[k] <= sc_reg[k-1];
            end
        end
    end

    assign out_vld     = vld_reg[NS-1];
    assign result_bits = q_reg[10];

endmodule

### hdl/fast_float_pow_exp2_log2.sv
// Fast single-precision pow(base, power) = exp2(power * log2(|base|)), 22-stage pipeline.
// Top level; instantiates ffpow_log2 and ffpow_exp2, uses ffpow_pkg.
//
// Accepts one base/power request per clock unless stalled and returns the results in order;
// each float add and multiply is IEEE single (round to nearest even, no fused
// operations); the whole pipeline advances together and freezes while a result
// waits on dst_stall. Sign of base and special values of base are not singled out; a NaN
// or over-range product saturates to +inf, a product below -126.99999 gives +0.
`timescale 1ns / 1ps
module fast_float_pow_exp2_log2
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [31:0] base_bits,
    input  logic [31:0] power_bits,
    output logic        dst_valid,
    input  logic        dst_stall,
    output logic [31:0] result_bits
);
    import ffpow_pkg::*;

    logic        adv;
    logic        lg_vld;
    logic [31:0] lg_bits;
    logic [31:0] pw_bits;
    logic        prod_vld_reg;
    logic [31:0] prod_reg;

    assign adv       = !(dst_valid && dst_stall);
    assign src_stall = !adv;

    ffpow_log2 u_log2
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_vld     (src_valid),
        .base_bits  (base_bits),
        .power_bits (power_bits),
        .out_vld    (lg_vld),
        .lg_bits    (lg_bits),
        .pw_bits    (pw_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_vld_reg <= lg_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= fp_mul(lg_bits, pw_bits);
        end
    end

    ffpow_exp2 u_exp2
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_vld      (prod_vld_reg),
        .x_bits      (prod_reg),
        .out_vld     (dst_valid),
        .result_bits (result_bits)
    );

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(prod_vld_reg) && $stable(prod_reg))
        else $error("pipeline moved while frozen");

    a_no_nan: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> !((result_bits[30:23] == 8'hFF) && (result_bits[22:0] != 23'd0)))
        else $error("NaN result");

    a_positive: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> !result_bits[31])
        else $error("negative result");

endmodule

### verif/testbench.sv
// Self-checking testbench for fast_float_pow_exp2_log2: directed and random requests,
// bit-exact single-precision prediction of exp2(power*log2|base|). Depends on ffpow_pkg.
`timescale 1ns / 1ps
module testbench;
    import ffpow_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [31:0] base_bits;
    logic [31:0] power_bits;
    logic        dst_valid;
    logic        dst_stall;
    logic [31:0] result_bits;

    logic [31:0] pending_results[$];
    int          mismatches;
    bit          quiet;

    fast_float_pow_exp2_log2 u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .base_bits  (base_bits),
        .power_bits (power_bits),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .result_bits(result_bits)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int flt_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic [23:0] flt_sig(input logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] ord_key(input logic [31:0] v);
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    // value = sig * 2^e, rounded to nearest even into single precision
    function automatic logic [31:0] flt_round(input logic s, input logic [319:0] sig,
                                              input int e);
        int           msb;
        int           lsb;
        int           k;
        logic [319:0] q;
        logic [319:0] rem;
        logic [319:0] half;
        longint       word;
        msb = -1;
        for (int i = 0; i < 320; i++)
        begin
            if (sig[i])
            begin
                msb = i;
            end
        end
        if (msb < 0)
        begin
            return {s, 31'd0};
        end
        lsb = e + msb - 23;
        if (lsb < -149)
        begin
            lsb = -149;
        end
        k = lsb - e;
        if (k <= 0)
        begin
            q = sig << (-k);
        end
        else
        begin
            q    = sig >> k;
            rem  = sig & ((320'd1 << k) - 320'd1);
            half = 320'd1 << (k - 1);
            if ((rem > half) || ((rem == half) && q[0]))
            begin
                q = q + 320'd1;
            end
        end
        if (q[24])
        begin
            q   = q >> 1;
            lsb = lsb + 1;
        end
        word = (longint'(lsb + 149) << 23) + longint'(q[24:0]);
        if (word >= 64'h7F80_0000)
        begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, word[30:0]};
    endfunction

    function automatic logic [31:0] flt_add(input logic [31:0] a, input logic [31:0] b);
        logic [319:0] ma;
        logic [319:0] mb;
        logic [319:0] r;
        logic         s;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
        begin
            return FP_QNAN;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        ma = 320'(flt_sig(a)) << (flt_exp(a) + 149);
        mb = 320'(flt_sig(b)) << (flt_exp(b) + 149);
        if (a[31] == b[31])
        begin
            r = ma + mb;
            s = a[31];
        end
        else if (ma >= mb)
        begin
            r = ma - mb;
            s = a[31];
        end
        else
        begin
            r = mb - ma;
            s = b[31];
        end
        if (r == 320'd0)
        begin
            return {(a[31] == b[31]) ? a[31] : 1'b0, 31'd0};
        end
        return flt_round(s, r, -149);
    endfunction

    function automatic logic [31:0] flt_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic za;
        logic zb;
        s  = a[31] ^ b[31];
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b) || (is_inf(a) && zb) || (is_inf(b) && za))
        begin
            return FP_QNAN;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (za || zb)
        begin
            return {s, 31'd0};
        end
        return flt_round(s, 320'(48'(flt_sig(a)) * 48'(flt_sig(b))),
                         flt_exp(a) + flt_exp(b));
    endfunction

    function automatic logic [31:0] int_to_flt(input int v);
        if (v == 0)
        begin
            return 32'd0;
        end
        return flt_round(v < 0, 320'((v < 0) ? -v : v), 0);
    endfunction

    // nearest integer, ties to even
    function automatic int nearest_int(input logic [31:0] t);
        int           e;
        int           mag;
        logic [319:0] sig;
        logic [319:0] rem;
        logic [319:0] half;
        e   = flt_exp(t);
        sig = 320'(flt_sig(t));
        if (e >= 0)
        begin
            mag = int'(sig << e);
        end
        else
        begin
            mag  = int'(sig >> (-e));
            rem  = sig & ((320'd1 << (-e)) - 320'd1);
            half = 320'd1 << (-e - 1);
            if ((rem > half) || ((rem == half) && mag[0]))
            begin
                mag = mag + 1;
            end
        end
        return t[31] ? -mag : mag;
    endfunction

    function automatic logic [31:0] pow_predict(input logic [31:0] b, input logic [31:0] pw);
        logic [31:0] m;
        logic [31:0] lg;
        logic [31:0] x;
        logic [31:0] frac;
        logic [31:0] q;
        logic [31:0] scale;
        int          ip;
        m  = {9'h07F, b[22:0]};
        lg = flt_mul(LG_C4, m);
        lg = flt_add(lg, LG_C3);
        lg = flt_mul(lg, m);
        lg = flt_add(lg, LG_C2);
        lg = flt_mul(lg, m);
        lg = flt_add(lg, LG_C1);
        lg = flt_mul(lg, m);
        lg = flt_add(lg, LG_C0);
        lg = flt_mul(lg, flt_add(m, FP_NEG_ONE));
        lg = flt_add(lg, int_to_flt(int'(b[30:23]) - 127));
        x  = flt_mul(lg, pw);
        if (is_nan(x) || !(ord_key(x) < ord_key(FP_CLAMP_HI)))
        begin
            x = FP_CLAMP_HI;
        end
        if (!(ord_key(FP_CLAMP_LO) < ord_key(x)))
        begin
            x = FP_CLAMP_LO;
        end
        ip    = nearest_int(flt_add(x, FP_NEG_HALF));
        frac  = flt_add(x, int_to_flt(-ip));
        scale = 32'((ip + 127) & 32'h1FF) << 23;
        q = flt_mul(EX_C3, frac);
        q = flt_add(q, EX_C2);
        q = flt_mul(q, frac);
        q = flt_add(q, EX_C1);
        q = flt_mul(q, frac);
        q = flt_add(q, EX_C0);
        return flt_mul(scale, q);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && src_valid && !src_stall)
        begin
            pending_results.push_back(pow_predict(base_bits, power_bits));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: result_bits=%h", result_bits);
                end
            end
            else
            begin
                if (result_bits !== pending_results[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: result_bits expected %h actual %h",
                                 pending_results[0], result_bits);
                    end
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        dst_stall <= quiet ? 1'b0 : ($urandom_range(99) < 26);
    end

    task automatic send_request(input logic [31:0] b, input logic [31:0] pw);
        if (!quiet && ($urandom_range(99) < 26))
        begin
            src_valid  <= 1'b0;
            base_bits  <= $urandom;
            power_bits <= $urandom;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        src_valid  <= 1'b1;
        base_bits  <= b;
        power_bits <= pw;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        logic [31:0] bases[9];
        logic [31:0] powers[12];
        bases  = '{32'h0000_0000, 32'h3F80_0000, 32'h4000_0000, 32'h0000_0001,
                   32'h7F80_0000, 32'h7FC0_0001, 32'hC100_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF};
        powers = '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
                   32'hFF80_0000, 32'h7FC0_0000, 32'h7149_F2CA, 32'h0000_0001,
                   32'h4301_0000, 32'hC2FD_FFFF, 32'h3F00_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < 12; i++)
        begin
            send_request(bases[i % 9], powers[i]);
        end
        for (int i = 0; i < 9; i++)
        begin
            send_request(bases[i], powers[(i * 5 + 3) % 12]);
        end
        send_request(32'h4000_0000, 32'h4300_8000);
        send_request(32'h4000_0000, 32'hC2FE_0000);
    endtask

    task automatic test_random_bits(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_request($urandom, $urandom);
        end
    endtask

    task automatic test_random_typical(input int n);
        logic [31:0] b;
        logic [31:0] pw;
        for (int i = 0; i < n; i++)
        begin
            b  = {1'($urandom), 8'($urandom_range(154, 100)), 23'($urandom)};
            pw = {1'($urandom), 8'($urandom_range(135, 105)), 23'($urandom)};
            send_request(b, pw);
        end
    endtask

    task automatic test_back_to_back(input int n);
        quiet = 1'b1;
        test_random_typical(n);
        quiet = 1'b0;
    endtask

    initial
    begin
        mismatches = 0;
        quiet      = 1'b0;
        rst_n      = 1'b0;
        src_valid  = 1'b0;
        base_bits  = 32'd0;
        power_bits = 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random_bits(400);
        test_random_typical(500);
        wait_drained();
        test_back_to_back(300);
        test_random_typical(330);
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/ffpow_pkg.sv
hdl/ffpow_log2.sv
hdl/ffpow_exp2.sv
hdl/fast_float_pow_exp2_log2.sv
verif/testbench.sv
